FILE: rtl/ufs_pkg.sv
package ufs_pkg;

  // Code points with a special meaning for file names, and the thresholds of the UTF-8 encoding lengths.
  localparam logic [20:0] CP_SPACE      = 21'h20;
  localparam logic [20:0] CP_SLASH      = 21'h2F;
  localparam logic [20:0] CP_BACKSLASH  = 21'h5C;
  localparam logic [20:0] CP_UNDERSCORE = 21'h5F;
  localparam logic [20:0] CP_DELETE     = 21'h7F;
  localparam logic [20:0] CP_TWO_BYTE   = 21'h80;
  localparam logic [20:0] CP_THREE_BYTE = 21'h800;
  localparam logic [20:0] CP_FOUR_BYTE  = 21'h10000;

  localparam logic [7:0] BYTE_UNDERSCORE = 8'h5F;
  localparam logic [7:0] LEAD_TWO        = 8'hC0;
  localparam logic [7:0] LEAD_THREE      = 8'hE0;
  localparam logic [7:0] LEAD_FOUR       = 8'hF0;
  localparam logic [7:0] CONT_MARK       = 8'h80;

  localparam int unsigned FallbackLen = 7;
  localparam logic [7:0] FALLBACK_NAME [FallbackLen] = '{
    8'h75, 8'h6E, 8'h6E, 8'h61, 8'h6D, 8'h65, 8'h64
  };

  // One queue entry: the code points decoded from one input item.
  typedef struct packed {
    logic [20:0] cp0;
    logic [20:0] cp1;
    logic [1:0]  ncp;
    logic        last;
  } ufs_entry_t;

  // One result item.
  typedef struct packed {
    logic [7:0] data;
    logic       bv;
    logic       last;
  } ufs_res_t;

  // Sequence length announced by a lead byte, 0 if it cannot lead.
  function automatic logic [2:0] lead_len(logic [7:0] b);
    logic [2:0] len;
    if (!b[7]) begin
      len = 3'd1;
    end else if (b[7:5] == 3'b110) begin
      len = 3'd2;
    end else if (b[7:4] == 4'b1110) begin
      len = 3'd3;
    end else if (b[7:3] == 5'b11110) begin
      len = 3'd4;
    end else begin
      len = 3'd0;
    end
    return len;
  endfunction

  // Code point of a sequence; fin is always its final byte.
  function automatic logic [20:0] cp_of(logic [7:0] lead, logic [7:0] m1,
                                        logic [7:0] m2, logic [7:0] fin,
                                        logic [2:0] len);
    logic [20:0] cp;
    case (len)
      3'd2: cp = {10'd0, lead[4:0], fin[5:0]};
      3'd3: cp = {5'd0, lead[3:0], m1[5:0], fin[5:0]};
      3'd4: cp = {lead[2:0], m1[5:0], m2[5:0], fin[5:0]};
      default: cp = {13'd0, lead};
    endcase
    return cp;
  endfunction

endpackage

FILE: rtl/ufs_in_if.sv
interface ufs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

FILE: rtl/ufs_out_if.sv
interface ufs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       out_last;

  modport source (output valid, output out_byte, output byte_valid, output out_last,
                  input ready);
  modport sink (input valid, input out_byte, input byte_valid, input out_last,
                output ready);
endinterface

FILE: rtl/utf8_filename_sanitizer.sv
// Turns a byte string into a safe file name. Input items are raw bytes with a
// last marker; the bytes are decoded as lenient UTF-8 (a lead byte takes the
// following bytes as continuation bytes whatever their value), control code
// points, slash, backslash and DEL are dropped, each run of spaces and
// underscores becomes a single underscore with leading and trailing runs
// removed, and the kept code points are re-encoded as UTF-8. Every string is
// closed by an end marker item (byte_valid low, out_last high); a string that
// yields no byte is named "unnamed". The front end decodes and accepts one
// input item per cycle as long as the queue of QueueDepth entries has room.
// The back end sends one result item per cycle into an output register while
// the receiver takes them, and yields no item for a dropped character, space
// or underscore. An end marker goes out alone, or after the fallback name.
// With mostly printable input and a ready receiver the sustained rate is one
// input item per cycle; the queue absorbs the bursts of multi-byte characters
// and end markers, and ready drops only when it fills.
module utf8_filename_sanitizer #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ufs_in_if.sink    in_chan_i,
  ufs_out_if.source out_chan_o
);
  import ufs_pkg::*;

  // Entries between the decoder and the encoder.
  logic       push, full, pop, empty;
  ufs_entry_t push_entry, pop_entry;

  ufs_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_chan_i (in_chan_i),
    .full_i    (full),
    .push_o    (push),
    .entry_o   (push_entry)
  );

  ufs_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .entry_o (pop_entry),
    .empty_o (empty)
  );

  // The back end owns the separator and empty-name state, so it sees code
  // points strictly in string order no matter how far the front runs ahead.
  ufs_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (empty),
    .entry_i    (pop_entry),
    .pop_o      (pop),
    .out_chan_o (out_chan_o)
  );

endmodule

FILE: rtl/ufs_front.sv
module ufs_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  ufs_in_if.sink              in_chan_i,
  input  logic                full_i,
  output logic                push_o,
  output ufs_pkg::ufs_entry_t entry_o
);
  import ufs_pkg::*;

  logic [7:0] held_q [3];
  logic [7:0] held_d [3];
  logic [1:0] cnt_q, cnt_d;
  logic [2:0] need_q, need_d;
  logic       accept;
  logic [7:0] b;
  logic [2:0] blen, xlen;
  logic       complete;

  assign in_chan_i.ready = !full_i;
  assign accept = in_chan_i.valid && !full_i;
  assign b = in_chan_i.in_byte;
  assign blen = lead_len(b);
  assign xlen = lead_len(held_q[1]);
  assign complete = (cnt_q != 2'd0) && (({1'b0, cnt_q} + 3'd1) >= need_q);

  always_comb begin
    held_d = held_q;
    cnt_d = cnt_q;
    need_d = need_q;
    entry_o = '{cp0: '0, cp1: '0, ncp: 2'd0, last: in_chan_i.in_last};
    if (in_chan_i.in_last) begin
      cnt_d = 2'd0;
      need_d = 3'd0;
      if (cnt_q == 2'd0) begin
        if (blen == 3'd1) begin
          entry_o.cp0 = {13'd0, b};
          entry_o.ncp = 2'd1;
        end
      end else if (complete) begin
        entry_o.cp0 = cp_of(held_q[0], held_q[1], held_q[2], b, need_q);
        entry_o.ncp = 2'd1;
      end else if (cnt_q == 2'd1) begin
        // The cut-off lead is skipped; the final byte stands alone.
        if (blen == 3'd1) begin
          entry_o.cp0 = {13'd0, b};
          entry_o.ncp = 2'd1;
        end
      end else begin
        // Two bytes remain after the skipped lead.
        if (xlen == 3'd1) begin
          entry_o.cp0 = {13'd0, held_q[1]};
          entry_o.ncp = 2'd1;
          if (blen == 3'd1) begin
            entry_o.cp1 = {13'd0, b};
            entry_o.ncp = 2'd2;
          end
        end else if (xlen == 3'd2) begin
          entry_o.cp0 = cp_of(held_q[1], 8'd0, 8'd0, b, 3'd2);
          entry_o.ncp = 2'd1;
        end else if (blen == 3'd1) begin
          entry_o.cp0 = {13'd0, b};
          entry_o.ncp = 2'd1;
        end
      end
    end else if (cnt_q == 2'd0) begin
      if (blen == 3'd1) begin
        entry_o.cp0 = {13'd0, b};
        entry_o.ncp = 2'd1;
      end else if (blen != 3'd0) begin
        held_d[0] = b;
        cnt_d = 2'd1;
        need_d = blen;
      end
    end else if (complete) begin
      entry_o.cp0 = cp_of(held_q[0], held_q[1], held_q[2], b, need_q);
      entry_o.ncp = 2'd1;
      cnt_d = 2'd0;
      need_d = 3'd0;
    end else begin
      held_d[cnt_q] = b;
      cnt_d = cnt_q + 2'd1;
    end
  end

  assign push_o = accept && (in_chan_i.in_last || (entry_o.ncp != 2'd0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      need_q <= 3'd0;
    end else if (accept) begin
      cnt_q <= cnt_d;
      need_q <= need_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      held_q <= held_d;
    end
  end

  a_held_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != 2'd0) |-> (({1'b0, cnt_q} < need_q) && (need_q >= 3'd2)))
    else $error("held sequence is not shorter than its announced length");
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_chan_i.in_last) |=> (cnt_q == 2'd0))
    else $error("held bytes survive the end of a string");
  a_last_pushes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_chan_i.in_last) |-> push_o)
    else $error("end of a string did not reach the queue");

endmodule

FILE: rtl/ufs_queue.sv
module ufs_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  ufs_pkg::ufs_entry_t entry_i,
  output logic                full_o,
  input  logic                pop_i,
  output ufs_pkg::ufs_entry_t entry_o,
  output logic                empty_o
);
  import ufs_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  ufs_entry_t      mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign entry_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("push into a full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("pop from an empty queue");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue count beyond depth");

endmodule

FILE: rtl/ufs_back.sv
module ufs_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                empty_i,
  input  ufs_pkg::ufs_entry_t entry_i,
  output logic                pop_o,
  ufs_out_if.source           out_chan_o
);
  import ufs_pkg::*;

  ufs_entry_t  cur_q;
  logic        cur_valid_q, cur_valid_d;
  logic [1:0]  unit_q, unit_d;
  logic [2:0]  idx_q, idx_d;
  logic        upend_q, upend_d;
  logic        emitted_q, emitted_d;
  logic        out_valid_q, out_valid_d;
  ufs_res_t    out_q;

  logic [20:0] cp;
  logic        is_cp, drop, space;
  logic [7:0]  enc [4];
  logic [3:0]  enc_n, n;
  ufs_res_t    seq [8];
  logic        out_free, step, finish, more, load;
  logic [1:0]  unit_nxt;

  assign cp = unit_q[0] ? cur_q.cp1 : cur_q.cp0;
  assign is_cp = unit_q < cur_q.ncp;
  assign drop = (cp < CP_SPACE) || (cp == CP_SLASH) || (cp == CP_BACKSLASH)
             || (cp == CP_DELETE);
  assign space = (cp == CP_SPACE) || (cp == CP_UNDERSCORE);

  // UTF-8 encoding of the current code point.
  always_comb begin
    enc = '{default: '0};
    if (cp < CP_TWO_BYTE) begin
      enc[0] = cp[7:0];
      enc_n = 4'd1;
    end else if (cp < CP_THREE_BYTE) begin
      enc[0] = LEAD_TWO | {3'd0, cp[10:6]};
      enc[1] = CONT_MARK | {2'd0, cp[5:0]};
      enc_n = 4'd2;
    end else if (cp < CP_FOUR_BYTE) begin
      enc[0] = LEAD_THREE | {4'd0, cp[15:12]};
      enc[1] = CONT_MARK | {2'd0, cp[11:6]};
      enc[2] = CONT_MARK | {2'd0, cp[5:0]};
      enc_n = 4'd3;
    end else begin
      enc[0] = LEAD_FOUR | {5'd0, cp[20:18]};
      enc[1] = CONT_MARK | {2'd0, cp[17:12]};
      enc[2] = CONT_MARK | {2'd0, cp[11:6]};
      enc[3] = CONT_MARK | {2'd0, cp[5:0]};
      enc_n = 4'd4;
    end
  end

  // Result items of the current unit, in order.
  always_comb begin
    seq = '{default: '0};
    n = 4'd0;
    if (!is_cp) begin
      if (!emitted_q) begin
        for (int k = 0; k < FallbackLen; k++) begin
          seq[k] = '{data: FALLBACK_NAME[k], bv: 1'b1, last: 1'b0};
        end
        seq[FallbackLen] = '{data: 8'd0, bv: 1'b0, last: 1'b1};
        n = 4'd8;
      end else begin
        seq[0] = '{data: 8'd0, bv: 1'b0, last: 1'b1};
        n = 4'd1;
      end
    end else if (!drop && !space) begin
      if (upend_q) begin
        seq[0] = '{data: BYTE_UNDERSCORE, bv: 1'b1, last: 1'b0};
        for (int k = 0; k < 4; k++) begin
          seq[k+1] = '{data: enc[k], bv: 1'b1, last: 1'b0};
        end
        n = enc_n + 4'd1;
      end else begin
        for (int k = 0; k < 4; k++) begin
          seq[k] = '{data: enc[k], bv: 1'b1, last: 1'b0};
        end
        n = enc_n;
      end
    end
  end

  assign out_free = !out_valid_q || out_chan_o.ready;
  assign step = cur_valid_q && ((n == 4'd0) || out_free);
  assign finish = step && ((n == 4'd0) || (({1'b0, idx_q} + 4'd1) == n));
  assign unit_nxt = unit_q + 2'd1;
  assign more = is_cp && ((unit_nxt < cur_q.ncp) || cur_q.last);
  assign load = !empty_i && (!cur_valid_q || (finish && !more));
  assign pop_o = load;

  always_comb begin
    cur_valid_d = cur_valid_q;
    unit_d = unit_q;
    idx_d = idx_q;
    upend_d = upend_q;
    emitted_d = emitted_q;
    out_valid_d = out_valid_q && !out_chan_o.ready;
    if (step && (n != 4'd0)) begin
      out_valid_d = 1'b1;
    end
    if (step && !finish) begin
      idx_d = idx_q + 3'd1;
    end
    if (finish) begin
      idx_d = 3'd0;
      if (!is_cp) begin
        upend_d = 1'b0;
        emitted_d = 1'b0;
      end else if (space) begin
        upend_d = upend_q || emitted_q;
      end else if (!drop) begin
        upend_d = 1'b0;
        emitted_d = 1'b1;
      end
      if (more) begin
        unit_d = unit_nxt;
      end else begin
        cur_valid_d = 1'b0;
      end
    end
    if (load) begin
      cur_valid_d = 1'b1;
      unit_d = 2'd0;
      idx_d = 3'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      unit_q <= 2'd0;
      idx_q <= 3'd0;
      upend_q <= 1'b0;
      emitted_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      unit_q <= unit_d;
      idx_q <= idx_d;
      upend_q <= upend_d;
      emitted_q <= emitted_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q <= entry_i;
    end
    if (step && (n != 4'd0)) begin
      out_q <= seq[idx_q];
    end
  end

  assign out_chan_o.valid = out_valid_q;
  assign out_chan_o.out_byte = out_q.data;
  assign out_chan_o.byte_valid = out_q.bv;
  assign out_chan_o.out_last = out_q.last;

  a_end_unit_has_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_valid_q && (unit_q >= cur_q.ncp)) |-> cur_q.last)
    else $error("end unit reached in an entry without an end marker");
  a_marker_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && (n != 4'd0) && seq[idx_q].last) |=> (!emitted_q && !upend_q))
    else $error("name state survives the end marker");
  a_pending_needs_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upend_q |-> emitted_q)
    else $error("separator pending before any byte of the name");
  a_marker_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.bv != out_q.last))
    else $error("result item is neither data nor end marker");

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import ufs_pkg::*;

  // The fallback name the block writes when a string keeps no byte at all.
  localparam string FALLBACK_TEXT = "unnamed";

  // Roughly 150 random input items follow the directed table.
  localparam int unsigned RANDOM_ITEMS = 150;
  // The long receiver hold-off, long enough to fill the queue and stall the input.
  localparam int unsigned HOLD_CYCLES = 120;
  // Quiet cycles after the last expected result; a stray extra item shows up here.
  localparam int unsigned DRAIN_CYCLES = 24;

  // How the expectation of a directed row is formed: from the predictor, or
  // typed in directly because it is obvious from the rules.
  typedef enum logic [1:0] {
    ROW_PREDICTED,
    ROW_UNNAMED,
    ROW_ECHO
  } row_kind_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
    row_kind_e  kind;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  ufs_in_if  in_chan ();
  ufs_out_if out_chan ();

  utf8_filename_sanitizer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_chan_i  (in_chan),
    .out_chan_o (out_chan)
  );

  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // The directed part. Each row with last set closes a string, so the typed
  // rows all start from the reset state and their output is plain to see.
  stim_row_t directed_rows [25] = '{
    // A single control byte is dropped, leaving nothing: the fallback name.
    '{8'h00, 1'b1, ROW_UNNAMED},
    // 0xFF can never lead a sequence and is skipped.
    '{8'hFF, 1'b1, ROW_UNNAMED},
    // A plain printable byte passes through unchanged.
    '{8'h41, 1'b1, ROW_ECHO},
    // DEL, slash and backslash are all dropped.
    '{8'h7F, 1'b1, ROW_UNNAMED},
    '{8'h2F, 1'b1, ROW_UNNAMED},
    '{8'h5C, 1'b1, ROW_UNNAMED},
    // A lone space or underscore is a leading run and vanishes.
    '{8'h20, 1'b1, ROW_UNNAMED},
    '{8'h5F, 1'b1, ROW_UNNAMED},
    // A continuation byte where a lead is expected is a stray byte.
    '{8'h80, 1'b1, ROW_UNNAMED},
    // A two-byte character is re-encoded as it came in.
    '{8'hC3, 1'b0, ROW_PREDICTED},
    '{8'hA9, 1'b1, ROW_PREDICTED},
    // Space, underscore and a dropped slash inside one run give one underscore.
    '{8'h61, 1'b0, ROW_PREDICTED},
    '{8'h20, 1'b0, ROW_PREDICTED},
    '{8'h5F, 1'b0, ROW_PREDICTED},
    '{8'h2F, 1'b0, ROW_PREDICTED},
    '{8'h62, 1'b1, ROW_PREDICTED},
    // A four-byte lead cut off by the end of the string is skipped, the bytes
    // after it are decoded on their own, and the trailing space vanishes.
    '{8'hF0, 1'b0, ROW_PREDICTED},
    '{8'h41, 1'b0, ROW_PREDICTED},
    '{8'h20, 1'b1, ROW_PREDICTED},
    // The largest code point that the bit arithmetic can form.
    '{8'hF7, 1'b0, ROW_PREDICTED},
    '{8'hBF, 1'b0, ROW_PREDICTED},
    '{8'hBF, 1'b0, ROW_PREDICTED},
    '{8'hBF, 1'b1, ROW_PREDICTED},
    // An overlong encoding of NUL decodes to a dropped code point.
    '{8'hC0, 1'b0, ROW_PREDICTED},
    '{8'h80, 1'b1, ROW_PREDICTED}
  };

  // ---------------------------------------------------------------------------
  // Name predictor. It keeps its own copy of the decoder state: the bytes of
  // a multi-byte sequence gathered so far, the length announced by its lead,
  // whether a run of spaces or underscores waits to be written as one '_',
  // and whether the current name has produced any byte yet.
  // ---------------------------------------------------------------------------
  logic [7:0]  seq_buf [3];
  int unsigned seq_fill;
  int unsigned seq_need;
  bit          run_pending;
  bit          name_begun;

  ufs_res_t    step_bytes[$];   // results of the item just accepted
  ufs_res_t    name_q[$];       // results still awaited from the block
  row_kind_e   row_kind_q[$];   // one entry per offered input item, in order
  logic [7:0]  string_bytes[$]; // scratch for building a random string

  int unsigned items_sent;
  int unsigned strings_sent;
  int unsigned results_seen;
  int unsigned mismatches;
  bit          no_idle;
  bit          hold_request;

  function automatic ufs_res_t res_item(logic [7:0] data, logic bv, logic last);
    ufs_res_t r;
    r.data = data;
    r.bv   = bv;
    r.last = last;
    return r;
  endfunction

  // Length of the sequence that a byte opens, or 0 if it cannot lead one.
  function automatic int unsigned seq_length(logic [7:0] b);
    int unsigned len;
    if (b[7] == 1'b0) begin
      len = 1;
    end else if (b[7:5] == 3'b110) begin
      len = 2;
    end else if (b[7:4] == 4'b1110) begin
      len = 3;
    end else if (b[7:3] == 5'b11110) begin
      len = 4;
    end else begin
      len = 0;
    end
    return len;
  endfunction

  // Lenient decode: continuation bytes contribute their low six bits whatever
  // their top bits are, and overlong forms are not rejected.
  function automatic logic [20:0] join_code_point(logic [3:0][7:0] seq, int unsigned len);
    logic [20:0] cp;
    case (len)
      2: cp = {10'd0, seq[0][4:0], seq[1][5:0]};
      3: cp = {5'd0, seq[0][3:0], seq[1][5:0], seq[2][5:0]};
      4: cp = {seq[0][2:0], seq[1][5:0], seq[2][5:0], seq[3][5:0]};
      default: cp = {13'd0, seq[0]};
    endcase
    return cp;
  endfunction

  // Shortest UTF-8 form of a code point; returns the number of bytes.
  function automatic int unsigned encode_utf8(logic [20:0] cp, output logic [3:0][7:0] enc);
    enc = '0;
    if (cp < CP_TWO_BYTE) begin
      enc[0] = cp[7:0];
      return 1;
    end
    if (cp < CP_THREE_BYTE) begin
      enc[0] = LEAD_TWO | {3'd0, cp[10:6]};
      enc[1] = CONT_MARK | {2'd0, cp[5:0]};
      return 2;
    end
    if (cp < CP_FOUR_BYTE) begin
      enc[0] = LEAD_THREE | {4'd0, cp[15:12]};
      enc[1] = CONT_MARK | {2'd0, cp[11:6]};
      enc[2] = CONT_MARK | {2'd0, cp[5:0]};
      return 3;
    end
    enc[0] = LEAD_FOUR | {5'd0, cp[20:18]};
    enc[1] = CONT_MARK | {2'd0, cp[17:12]};
    enc[2] = CONT_MARK | {2'd0, cp[11:6]};
    enc[3] = CONT_MARK | {2'd0, cp[5:0]};
    return 4;
  endfunction

  // Filters one decoded code point and appends the bytes it produces.
  function automatic void keep_code_point(logic [20:0] cp);
    logic [3:0][7:0] enc;
    int unsigned     len;
    if (cp < CP_SPACE || cp == CP_SLASH || cp == CP_BACKSLASH || cp == CP_DELETE) begin
      return;
    end
    // Spaces and underscores only mark a run; a leading run is forgotten.
    if (cp == CP_SPACE || cp == CP_UNDERSCORE) begin
      if (name_begun) begin
        run_pending = 1'b1;
      end
      return;
    end
    if (run_pending) begin
      step_bytes.insert(step_bytes.size(), res_item(BYTE_UNDERSCORE, 1'b1, 1'b0));
      run_pending = 1'b0;
    end
    len = encode_utf8(cp, enc);
    for (int unsigned k = 0; k < len; k++) begin
      step_bytes.insert(step_bytes.size(), res_item(enc[k], 1'b1, 1'b0));
    end
    name_begun = 1'b1;
  endfunction

  // At the end of a string the held bytes and the last byte are decoded
  // again from the start; a lead whose sequence does not fit is skipped.
  function automatic void decode_tail(logic [3:0][7:0] tail, int unsigned n);
    logic [3:0][7:0] sub;
    int unsigned     i;
    int unsigned     len;
    i = 0;
    while (i < n) begin
      len = seq_length(tail[i]);
      if (len >= 1 && i + len <= n) begin
        sub = '0;
        for (int unsigned k = 0; k < len; k++) begin
          sub[k] = tail[i + k];
        end
        keep_code_point(join_code_point(sub, len));
        i += len;
      end else begin
        i++;
      end
    end
  endfunction

  function automatic void clear_name_state();
    foreach (seq_buf[k]) begin
      seq_buf[k] = 8'h00;
    end
    seq_fill    = 0;
    seq_need    = 0;
    run_pending = 1'b0;
    name_begun  = 1'b0;
  endfunction

  // Works out the results of one accepted input item into step_bytes.
  function automatic void predict_name_bytes(logic [7:0] b, logic last);
    logic [3:0][7:0] seq;
    int unsigned     len;
    step_bytes.delete();
    seq = '0;
    for (int unsigned k = 0; k < seq_fill; k++) begin
      seq[k] = seq_buf[k];
    end
    seq[seq_fill] = b;
    if (last) begin
      decode_tail(seq, seq_fill + 1);
      if (!name_begun) begin
        for (int k = 0; k < FALLBACK_TEXT.len(); k++) begin
          step_bytes.insert(step_bytes.size(), res_item(FALLBACK_TEXT[k], 1'b1, 1'b0));
        end
      end
      step_bytes.insert(step_bytes.size(), res_item(8'h00, 1'b0, 1'b1));
      clear_name_state();
    end else if (seq_fill == 0) begin
      len = seq_length(b);
      if (len == 1) begin
        keep_code_point({13'd0, b});
      end else if (len > 1) begin
        seq_buf[0] = b;
        seq_fill   = 1;
        seq_need   = len;
      end
    end else if (seq_fill + 1 >= seq_need) begin
      keep_code_point(join_code_point(seq, seq_fill + 1));
      seq_fill = 0;
      seq_need = 0;
    end else begin
      seq_buf[seq_fill] = b;
      seq_fill++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Port watcher. Both handshakes are sampled at the rising edge, before the
  // block's registers and the testbench's own drives have moved, so the
  // values seen are the ones that took part in the transfer.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : watch_ports
    ufs_res_t  got;
    ufs_res_t  want;
    row_kind_e kind;
    if (rst_ni) begin
      if (in_chan.valid && in_chan.ready) begin
        kind = (row_kind_q.size() != 0) ? row_kind_q.pop_front() : ROW_PREDICTED;
        predict_name_bytes(in_chan.in_byte, in_chan.in_last);
        // Typed rows replace the predicted bytes; the predictor still ran so
        // its state stays in step with the block.
        if (kind == ROW_UNNAMED) begin
          step_bytes.delete();
          for (int k = 0; k < FALLBACK_TEXT.len(); k++) begin
            step_bytes.insert(step_bytes.size(), res_item(FALLBACK_TEXT[k], 1'b1, 1'b0));
          end
          step_bytes.insert(step_bytes.size(), res_item(8'h00, 1'b0, 1'b1));
        end else if (kind == ROW_ECHO) begin
          step_bytes.delete();
          step_bytes.insert(step_bytes.size(), res_item(in_chan.in_byte, 1'b1, 1'b0));
          step_bytes.insert(step_bytes.size(), res_item(8'h00, 1'b0, 1'b1));
        end
        foreach (step_bytes[k]) begin
          name_q.insert(name_q.size(), step_bytes[k]);
        end
      end

      if (out_chan.valid && out_chan.ready) begin
        got = res_item(out_chan.out_byte, out_chan.byte_valid, out_chan.out_last);
        results_seen++;
        if (name_q.size() == 0) begin
          if (mismatches < 10) begin
            $display("%0t: unexpected result item: byte %h bv %b last %b",
                     $realtime, got.data, got.bv, got.last);
          end
          mismatches++;
        end else begin
          want = name_q.pop_front();
          if (got.data !== want.data || got.bv !== want.bv || got.last !== want.last) begin
            if (mismatches < 10) begin
              $display("%0t: result %0d: expected byte %h bv %b last %b, got byte %h bv %b last %b",
                       $realtime, results_seen, want.data, want.bv, want.last,
                       got.data, got.bv, got.last);
            end
            mismatches++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side.
  // ---------------------------------------------------------------------------

  // Offers one byte after a random gap and waits until the block takes it.
  // With no gap, valid simply stays high from the previous item.
  task automatic send_byte(logic [7:0] b, logic last, row_kind_e kind);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    row_kind_q.insert(row_kind_q.size(), kind);
    in_chan.valid   <= 1'b1;
    in_chan.in_byte <= b;
    in_chan.in_last <= last;
    do @(posedge clk_i); while (!in_chan.ready);
    items_sent++;
  endtask

  // Appends the first keep bytes of the UTF-8 form of a code point; a keep
  // below the full length leaves a sequence cut short.
  function automatic void push_code_point(logic [20:0] cp, int unsigned keep);
    logic [3:0][7:0] enc;
    int unsigned     len;
    len = encode_utf8(cp, enc);
    for (int unsigned k = 0; k < len && k < keep; k++) begin
      string_bytes.insert(string_bytes.size(), enc[k]);
    end
  endfunction

  // Builds one random string into string_bytes. Most strings are UTF-8 with a
  // mix of kept, dropped and run characters and an odd random byte; some end in a
  // truncated sequence, and a few are raw byte noise.
  function automatic void build_random_string();
    int unsigned n;
    int unsigned pick;
    logic [20:0] cp;
    string_bytes.delete();
    if ($urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, 6);
      for (int unsigned k = 0; k < n; k++) begin
        string_bytes.insert(string_bytes.size(), 8'($urandom_range(0, 255)));
      end
      return;
    end
    n = $urandom_range(1, 8);
    for (int unsigned k = 0; k < n; k++) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0, 1, 2, 3: push_code_point(21'($urandom_range(8'h21, 8'h7E)), 4);
        4: push_code_point($urandom_range(0, 1) ? CP_SPACE : CP_UNDERSCORE, 4);
        5: begin
          cp = $urandom_range(0, 4) == 0 ? CP_DELETE : 21'($urandom_range(0, 8'h1F));
          push_code_point(cp, 4);
        end
        6: push_code_point(21'($urandom_range(12'h080, 12'h7FF)), 4);
        7: push_code_point(21'($urandom_range(16'h0800, 16'hFFFF)), 4);
        8: push_code_point(21'($urandom_range(21'h10000, 21'h10FFFF)), 4);
        default: string_bytes.insert(string_bytes.size(), 8'($urandom_range(0, 255)));
      endcase
    end
    // A multi-byte character cut off by the end of the string.
    if ($urandom_range(0, 4) == 0) begin
      case ($urandom_range(0, 2))
        0: push_code_point(21'($urandom_range(12'h080, 12'h7FF)), 1);
        1: push_code_point(21'($urandom_range(16'h0800, 16'hFFFF)), $urandom_range(1, 2));
        default: push_code_point(21'($urandom_range(21'h10000, 21'h10FFFF)),
                                 $urandom_range(1, 3));
      endcase
    end
  endfunction

  // Receiver: a random stall before each result item, one long hold-off on
  // request, and no stalls at all while no_idle is set.
  initial begin : receive_side
    int unsigned stall;
    out_chan.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      stall = no_idle ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk_i); while (!out_chan.valid);
    end
  end

  // Main sequence: reset, directed table, random strings, drain, verdict.
  initial begin : stimulus
    int unsigned random_items;
    rst_ni          = 1'b0;
    in_chan.valid   <= 1'b0;
    in_chan.in_byte <= 8'h00;
    in_chan.in_last <= 1'b0;
    no_idle         = 1'b0;
    hold_request    = 1'b0;
    items_sent      = 0;
    strings_sent    = 0;
    results_seen    = 0;
    mismatches      = 0;
    random_items    = 0;
    clear_name_state();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_byte(directed_rows[i].in_byte, directed_rows[i].in_last, directed_rows[i].kind);
      if (directed_rows[i].in_last) begin
        strings_sent++;
      end
    end

    while (random_items < RANDOM_ITEMS) begin
      // At the start of the random part the receiver stops for a long while;
      // the sender keeps offering, so the queue fills and ready must drop.
      if (random_items == 0) begin
        hold_request = 1'b1;
      end
      // A stretch in the middle runs back to back on both sides.
      no_idle = (random_items >= 70 && random_items < 120);
      build_random_string();
      foreach (string_bytes[k]) begin
        send_byte(string_bytes[k], k == string_bytes.size() - 1, ROW_PREDICTED);
      end
      random_items += string_bytes.size();
      strings_sent++;
    end
    no_idle = 1'b0;
    in_chan.valid <= 1'b0;

    // Let the watcher see the last transfer, then wait for every result.
    @(posedge clk_i);
    while (name_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Run covered %0d input items in %0d strings and compared %0d result items.",
             items_sent, strings_sent, results_seen);
    $display("Mismatches: %0d; results still awaited: %0d.", mismatches, name_q.size());
    if (mismatches == 0 && name_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin : watchdog
    #2000000;
    $display("Timeout: %0d results still awaited.", name_q.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: utf8_filename_sanitizer.f
rtl/ufs_pkg.sv
rtl/ufs_in_if.sv
rtl/ufs_out_if.sv
rtl/ufs_front.sv
rtl/ufs_queue.sv
rtl/ufs_back.sv
rtl/utf8_filename_sanitizer.sv
bench/testbench.sv
